/* rtl/core/mhpq_pkg.sv */
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared constants, types and value conversions of the max-heap priority queue.
// ----------------------------------------------------------------------------
package mhpq_pkg;

    localparam int HEAP_DEPTH  = 1024;
    localparam int VALUE_WIDTH = 32;
    localparam int FIELD_W     = 32;
    localparam int ADDR_W      = $clog2(HEAP_DEPTH);
    localparam int COUNT_W     = $clog2(HEAP_DEPTH + 1);
    localparam int IDX_W       = ADDR_W + 2;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    typedef logic [VALUE_WIDTH-1:0] heap_val_t;
    typedef logic [ADDR_W-1:0]      heap_addr_t;
    typedef logic [COUNT_W-1:0]     heap_count_t;

    typedef struct packed {
        logic       rd_en;
        heap_addr_t rd_addr;
        logic       wr_en;
        heap_addr_t wr_addr;
        heap_val_t  wr_data;
    } ram_req_t;

    typedef struct packed {
        logic [FIELD_W-1:0] removed_value;
        logic [FIELD_W-1:0] top_value;
        heap_count_t        entry_count;
        logic               refused;
    } heap_res_t;

    // low bits of the input field, zero above the field
    function automatic heap_val_t to_heap_val(input logic [FIELD_W-1:0] v);
        heap_val_t r;
        r = '0;
        for (int i = 0; i < VALUE_WIDTH; i++)
        begin
            if (i < FIELD_W)
            begin
                r[i] = v[i];
            end
        end
        return r;
    endfunction

    // sign extend or cut to the output field
    function automatic logic [FIELD_W-1:0] to_field(input heap_val_t v);
        logic [FIELD_W-1:0] r;
        for (int i = 0; i < FIELD_W; i++)
        begin
            if (i < VALUE_WIDTH)
            begin
                r[i] = v[i];
            end
            else
            begin
                r[i] = v[VALUE_WIDTH-1];
            end
        end
        return r;
    endfunction

endpackage

/* rtl/core/max_heap_priority_queue.sv */
// ----------------------------------------------------------------------------
// max_heap_priority_queue
// Binary max-heap of signed values held in a single RAM, one result per item.
// ----------------------------------------------------------------------------
// One item at a time. The moving entry travels k levels, up to 10 at 1024
// entries. Each level on the way up costs one read and one write of the heap
// RAM. Each level on the way down costs up to two reads and one write. Both
// are followed by a root readback. A refused insert skips the sift but still
// reads back the root; a delete that empties the heap and a refused delete
// skip the readback. An output stall holds the finished item until it is taken.
// The result waits in an output register, so the next item is taken while
// it is still unclaimed. Ties between children go to the left child.
module max_heap_priority_queue (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             command,
    input  logic [mhpq_pkg::FIELD_W-1:0]     value,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [mhpq_pkg::FIELD_W-1:0]     removed_value,
    output logic [mhpq_pkg::FIELD_W-1:0]     top_value,
    output logic [mhpq_pkg::COUNT_W-1:0]     entry_count,
    output logic                             refused
);

    mhpq_pkg::ram_req_t  ram_req;
    mhpq_pkg::heap_val_t ram_rd_data;
    mhpq_pkg::heap_res_t res;
    mhpq_pkg::heap_res_t out_reg;
    logic                res_valid;
    logic                res_ready;
    logic                out_valid_reg;

    mhpq_ram #(
        .WIDTH (mhpq_pkg::VALUE_WIDTH),
        .DEPTH (mhpq_pkg::HEAP_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_req.wr_en),
        .wr_addr (ram_req.wr_addr),
        .wr_data (ram_req.wr_data),
        .rd_en   (ram_req.rd_en),
        .rd_addr (ram_req.rd_addr),
        .rd_data (ram_rd_data)
    );

    mhpq_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .value       (value),
        .ram_req     (ram_req),
        .ram_rd_data (ram_rd_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign removed_value = out_reg.removed_value;
    assign top_value     = out_reg.top_value;
    assign entry_count   = out_reg.entry_count;
    assign refused       = out_reg.refused;

endmodule

/* rtl/core/mhpq_ram.sv */
// ----------------------------------------------------------------------------
// mhpq_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module mhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/core/mhpq_ctrl.sv */
// ----------------------------------------------------------------------------
// mhpq_ctrl
// Sift sequencer: walks the heap one level at a time through the heap RAM,
// carrying the moving entry in a register and writing each displaced entry into the hole.
// ----------------------------------------------------------------------------
module mhpq_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            command,
    input  logic [mhpq_pkg::FIELD_W-1:0]    value,
    output mhpq_pkg::ram_req_t              ram_req,
    input  mhpq_pkg::heap_val_t             ram_rd_data,
    output logic                            res_valid,
    input  logic                            res_ready,
    output mhpq_pkg::heap_res_t             res
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_UP_CHK   = 4'd1;
    localparam logic [3:0] ST_UP_CMP   = 4'd2;
    localparam logic [3:0] ST_DN_ROOT  = 4'd3;
    localparam logic [3:0] ST_DN_LAST  = 4'd4;
    localparam logic [3:0] ST_DN_LOAD  = 4'd5;
    localparam logic [3:0] ST_DN_CHK   = 4'd6;
    localparam logic [3:0] ST_DN_LEFT  = 4'd7;
    localparam logic [3:0] ST_DN_CMP   = 4'd8;
    localparam logic [3:0] ST_TOP_RD   = 4'd9;
    localparam logic [3:0] ST_TOP_CAP  = 4'd10;
    localparam logic [3:0] ST_OUT      = 4'd11;

    logic [3:0]                 state_reg, state_next;
    mhpq_pkg::heap_count_t      count_reg, count_next;
    mhpq_pkg::heap_addr_t       pos_reg, pos_next;
    mhpq_pkg::heap_val_t        cur_reg, cur_next;
    mhpq_pkg::heap_val_t        left_reg, left_next;
    logic [mhpq_pkg::FIELD_W-1:0] removed_reg, removed_next;
    logic [mhpq_pkg::FIELD_W-1:0] top_reg, top_next;
    logic                       refused_reg, refused_next;

    logic                       in_fire;
    mhpq_pkg::heap_addr_t       parent_addr;
    logic [mhpq_pkg::IDX_W-1:0] lc_idx;
    logic [mhpq_pkg::IDX_W-1:0] rc_idx;
    logic [mhpq_pkg::IDX_W-1:0] count_idx;
    logic                       rc_ok;
    logic                       pick_right;
    mhpq_pkg::heap_val_t        pick_val;
    mhpq_pkg::heap_addr_t       pick_addr;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign res_valid = (state_reg == ST_OUT);

    assign res.removed_value = removed_reg;
    assign res.top_value     = top_reg;
    assign res.entry_count   = count_reg;
    assign res.refused       = refused_reg;

    assign parent_addr = mhpq_pkg::ADDR_W'((pos_reg - mhpq_pkg::ADDR_W'(1)) >> 1);
    assign lc_idx      = mhpq_pkg::IDX_W'({pos_reg, 1'b1});
    assign rc_idx      = lc_idx + mhpq_pkg::IDX_W'(1);
    assign count_idx   = mhpq_pkg::IDX_W'(count_reg);
    assign rc_ok       = (rc_idx < count_idx);
    assign pick_right  = rc_ok && ($signed(ram_rd_data) > $signed(left_reg));
    assign pick_val    = pick_right ? ram_rd_data : left_reg;
    assign pick_addr   = pick_right ? mhpq_pkg::ADDR_W'(rc_idx) : mhpq_pkg::ADDR_W'(lc_idx);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        pos_next     = pos_reg;
        cur_next     = cur_reg;
        left_next    = left_reg;
        removed_next = removed_reg;
        top_next     = top_reg;
        refused_next = refused_reg;
        ram_req      = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    removed_next = '0;
                    refused_next = 1'b0;
                    if (command == mhpq_pkg::CMD_INSERT)
                    begin
                        if (count_reg == mhpq_pkg::COUNT_W'(mhpq_pkg::HEAP_DEPTH))
                        begin
                            refused_next = 1'b1;
                            state_next   = ST_TOP_RD;
                        end
                        else
                        begin
                            cur_next   = mhpq_pkg::to_heap_val(value);
                            pos_next   = mhpq_pkg::ADDR_W'(count_reg);
                            count_next = count_reg + mhpq_pkg::COUNT_W'(1);
                            state_next = ST_UP_CHK;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            refused_next = 1'b1;
                            top_next     = '0;
                            state_next   = ST_OUT;
                        end
                        else
                        begin
                            count_next = count_reg - mhpq_pkg::COUNT_W'(1);
                            state_next = ST_DN_ROOT;
                        end
                    end
                end
            end
            ST_UP_CHK:
            begin
                if (pos_reg == '0)
                begin
                    ram_req.wr_en   = 1'b1;
                    ram_req.wr_addr = pos_reg;
                    ram_req.wr_data = cur_reg;
                    state_next      = ST_TOP_RD;
                end
                else
                begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = parent_addr;
                    state_next      = ST_UP_CMP;
                end
            end
            ST_UP_CMP:
            begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = pos_reg;
                if ($signed(ram_rd_data) < $signed(cur_reg))
                begin
                    ram_req.wr_data = ram_rd_data;
                    pos_next        = parent_addr;
                    state_next      = ST_UP_CHK;
                end
                else
                begin
                    ram_req.wr_data = cur_reg;
                    state_next      = ST_TOP_RD;
                end
            end
            ST_DN_ROOT:
            begin
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = '0;
                state_next      = ST_DN_LAST;
            end
            ST_DN_LAST:
            begin
                removed_next = mhpq_pkg::to_field(ram_rd_data);
                if (count_reg == '0)
                begin
                    top_next   = '0;
                    state_next = ST_OUT;
                end
                else
                begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = mhpq_pkg::ADDR_W'(count_reg);
                    state_next      = ST_DN_LOAD;
                end
            end
            ST_DN_LOAD:
            begin
                cur_next   = ram_rd_data;
                pos_next   = '0;
                state_next = ST_DN_CHK;
            end
            ST_DN_CHK:
            begin
                if (lc_idx >= count_idx)
                begin
                    ram_req.wr_en   = 1'b1;
                    ram_req.wr_addr = pos_reg;
                    ram_req.wr_data = cur_reg;
                    state_next      = ST_TOP_RD;
                end
                else
                begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = mhpq_pkg::ADDR_W'(lc_idx);
                    state_next      = ST_DN_LEFT;
                end
            end
            ST_DN_LEFT:
            begin
                left_next       = ram_rd_data;
                ram_req.rd_en   = rc_ok;
                ram_req.rd_addr = mhpq_pkg::ADDR_W'(rc_idx);
                state_next      = ST_DN_CMP;
            end
            ST_DN_CMP:
            begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = pos_reg;
                if ($signed(pick_val) > $signed(cur_reg))
                begin
                    ram_req.wr_data = pick_val;
                    pos_next        = pick_addr;
                    state_next      = ST_DN_CHK;
                end
                else
                begin
                    ram_req.wr_data = cur_reg;
                    state_next      = ST_TOP_RD;
                end
            end
            ST_TOP_RD:
            begin
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = '0;
                state_next      = ST_TOP_CAP;
            end
            ST_TOP_CAP:
            begin
                top_next   = (count_reg == '0) ? '0 : mhpq_pkg::to_field(ram_rd_data);
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        cur_reg     <= cur_next;
        left_reg    <= left_next;
        removed_reg <= removed_next;
        top_reg     <= top_next;
        refused_reg <= refused_next;
    end

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        ram_req.wr_en && ram_req.rd_en |-> ram_req.wr_addr != ram_req.rd_addr)
        else $error("heap ram read and write hit the same entry");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= mhpq_pkg::COUNT_W'(mhpq_pkg::HEAP_DEPTH))
        else $error("heap count beyond depth");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && command == mhpq_pkg::CMD_INSERT
            && count_reg != mhpq_pkg::COUNT_W'(mhpq_pkg::HEAP_DEPTH)
        |=> count_reg == $past(count_reg) + mhpq_pkg::COUNT_W'(1))
        else $error("accepted insert did not grow the heap");

    a_stable_count: assert property (@(posedge clk) disable iff (!rst_n)
        !in_fire |=> count_reg == $past(count_reg))
        else $error("heap count changed without an accepted item");

endmodule

/* tb/heap_result_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// heap_result_checker
// Watches both channels of the max-heap priority queue. Every accepted item is
// applied to a behavioral max-heap, and the result it should produce is queued.
// Every accepted result is compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module heap_result_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic                         command,
    input  logic [mhpq_pkg::FIELD_W-1:0] value,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic [mhpq_pkg::FIELD_W-1:0] removed_value,
    input  logic [mhpq_pkg::FIELD_W-1:0] top_value,
    input  logic [mhpq_pkg::COUNT_W-1:0] entry_count,
    input  logic                         refused,
    output int                           mismatches,
    output int                           pending
);

    import mhpq_pkg::*;

    typedef logic signed [VALUE_WIDTH-1:0] heap_sval_t;

    heap_sval_t model_entries [HEAP_DEPTH];
    int         model_size;
    heap_res_t  expected_results [$];
    int         error_total;
    int         reported;

    function automatic logic [FIELD_W-1:0] widen(input heap_sval_t v);
        logic signed [FIELD_W-1:0] ext;
        ext = v;
        return ext;
    endfunction

    function automatic heap_res_t apply_heap_op(input logic cmd,
                                                input logic [FIELD_W-1:0] val);
        heap_res_t  res;
        int         pos;
        int         parent;
        int         lc;
        int         rc;
        int         pick;
        heap_sval_t tmp;
        res = '0;
        if (cmd == CMD_INSERT)
        begin
            if (model_size >= HEAP_DEPTH)
            begin
                res.refused = 1'b1;
            end
            else
            begin
                pos = model_size;
                model_entries[pos] = VALUE_WIDTH'(val);
                model_size++;
                while (pos != 0)
                begin
                    parent = (pos - 1) / 2;
                    if (model_entries[parent] < model_entries[pos])
                    begin
                        tmp = model_entries[parent];
                        model_entries[parent] = model_entries[pos];
                        model_entries[pos] = tmp;
                        pos = parent;
                    end
                    else
                    begin
                        break;
                    end
                end
            end
        end
        else
        begin
            if (model_size == 0)
            begin
                res.refused = 1'b1;
            end
            else
            begin
                res.removed_value = widen(model_entries[0]);
                model_size--;
                if (model_size > 0)
                begin
                    model_entries[0] = model_entries[model_size];
                    pos = 0;
                    forever
                    begin
                        lc = pos * 2 + 1;
                        rc = pos * 2 + 2;
                        if (lc >= model_size)
                        begin
                            break;
                        end
                        pick = lc;
                        // left child wins a tie
                        if (rc < model_size && model_entries[rc] > model_entries[lc])
                        begin
                            pick = rc;
                        end
                        if (model_entries[pick] > model_entries[pos])
                        begin
                            tmp = model_entries[pick];
                            model_entries[pick] = model_entries[pos];
                            model_entries[pos] = tmp;
                            pos = pick;
                        end
                        else
                        begin
                            break;
                        end
                    end
                end
            end
        end
        res.top_value   = (model_size > 0) ? widen(model_entries[0]) : '0;
        res.entry_count = COUNT_W'(model_size);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        heap_res_t want;
        if (!rst_n)
        begin
            model_size = 0;
            expected_results.delete();
            error_total = 0;
            reported    = 0;
            mismatches <= 0;
            pending    <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    error_total++;
                    if (reported < 10)
                    begin
                        reported++;
                        $display("%0t: unexpected result removed=%h top=%h count=%0d refused=%b",
                                 $realtime, removed_value, top_value, entry_count, refused);
                    end
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (removed_value !== want.removed_value || top_value !== want.top_value
                        || entry_count !== want.entry_count || refused !== want.refused)
                    begin
                        error_total++;
                        if (reported < 10)
                        begin
                            reported++;
                            $display("%0t: result mismatch", $realtime);
                            $display("    expected removed=%h top=%h count=%0d refused=%b",
                                     want.removed_value, want.top_value, want.entry_count,
                                     want.refused);
                            $display("    actual   removed=%h top=%h count=%0d refused=%b",
                                     removed_value, top_value, entry_count, refused);
                        end
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                expected_results.insert(expected_results.size(),
                                        apply_heap_op(command, value));
            end
            mismatches <= error_total;
            pending    <= expected_results.size();
        end
    end

endmodule

/* tb/max_heap_priority_queue_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// max_heap_priority_queue_tb
// Drives insert and delete items into the max-heap priority queue: a directed
// run over extreme values, ties and refusals on an empty heap, a random mix
// with idling on both sides, then a drain back to empty and past it.
// Results are checked by the checker.
// ----------------------------------------------------------------------------
module max_heap_priority_queue_tb;

    import mhpq_pkg::*;

    localparam int RANDOM_ITEMS = 420;
    localparam int STALL_LIMIT  = 5000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic               command;
    logic [FIELD_W-1:0] value;
    logic               out_valid;
    logic               out_ready;
    logic [FIELD_W-1:0] removed_value;
    logic [FIELD_W-1:0] top_value;
    logic [COUNT_W-1:0] entry_count;
    logic               refused;

    int   mismatches;
    int   pending;
    int   occupancy;
    int   stall_cycles;
    logic steady_flow;

    max_heap_priority_queue DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .value         (value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .removed_value (removed_value),
        .top_value     (top_value),
        .entry_count   (entry_count),
        .refused       (refused)
    );

    heap_result_checker result_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .value         (value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .removed_value (removed_value),
        .top_value     (top_value),
        .entry_count   (entry_count),
        .refused       (refused),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    always #5 clk = ~clk;

    // result side back-pressure
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            out_ready <= steady_flow || ($urandom_range(0, 99) >= 29);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                stall_cycles <= 0;
            end
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
                $display("** max_heap_priority_queue: FAILED **");
                $finish;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    function automatic logic [FIELD_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 45)
        begin
            // narrow range, lots of ties
            return FIELD_W'(int'($urandom_range(0, 15)) - 8);
        end
        else if (sel < 60)
        begin
            case ($urandom_range(0, 3))
                0: return {1'b0, {(FIELD_W-1){1'b1}}};
                1: return {1'b1, {(FIELD_W-1){1'b0}}};
                2: return '0;
                default: return '1;
            endcase
        end
        return FIELD_W'($urandom);
    endfunction

    task automatic send_item(input logic cmd, input logic [FIELD_W-1:0] val);
        if (!steady_flow)
        begin
            while ($urandom_range(0, 99) < 29)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        command  <= cmd;
        value    <= val;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        if (cmd == CMD_INSERT && occupancy < HEAP_DEPTH)
        begin
            occupancy++;
        end
        else if (cmd == CMD_DELETE && occupancy > 0)
        begin
            occupancy--;
        end
    endtask

    task automatic wait_results_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        logic cmd;
        clk          = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        command      = CMD_INSERT;
        value        = '0;
        out_ready    = 1'b0;
        occupancy    = 0;
        stall_cycles = 0;
        steady_flow  = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty heap, extremes, ties, drain past empty
        send_item(CMD_DELETE, '1);
        send_item(CMD_INSERT, '0);
        send_item(CMD_INSERT, {1'b0, {(FIELD_W-1){1'b1}}});
        send_item(CMD_INSERT, {1'b1, {(FIELD_W-1){1'b0}}});
        send_item(CMD_INSERT, '1);
        send_item(CMD_INSERT, FIELD_W'(1));
        send_item(CMD_INSERT, {1'b0, {(FIELD_W-1){1'b1}}});
        send_item(CMD_INSERT, FIELD_W'(5));
        send_item(CMD_INSERT, FIELD_W'(5));
        send_item(CMD_INSERT, FIELD_W'(5));
        for (int i = 0; i < 10; i++)
        begin
            send_item(CMD_DELETE, FIELD_W'($urandom));
        end
        send_item(CMD_INSERT, {1'b1, {(FIELD_W-1){1'b0}}});
        send_item(CMD_DELETE, '0);

        // random mix, first growing then shrinking
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == 150)
            begin
                steady_flow <= 1'b1;
            end
            if (i == 260)
            begin
                steady_flow <= 1'b0;
            end
            if (i == 320)
            begin
                wait_results_drained();
            end
            if (i < RANDOM_ITEMS / 2)
            begin
                cmd = ($urandom_range(0, 99) < 65) ? CMD_INSERT : CMD_DELETE;
            end
            else
            begin
                cmd = ($urandom_range(0, 99) < 40) ? CMD_INSERT : CMD_DELETE;
            end
            send_item(cmd, pick_value());
        end

        // drain to empty, then delete against the empty heap
        while (occupancy > 0)
        begin
            send_item(CMD_DELETE, pick_value());
        end
        send_item(CMD_DELETE, pick_value());
        send_item(CMD_DELETE, pick_value());

        wait_results_drained();
        repeat (60) @(posedge clk);
        if (mismatches == 0 && pending == 0)
        begin
            $display("** max_heap_priority_queue: PASSED **");
        end
        else
        begin
            $display("** max_heap_priority_queue: FAILED **");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/mhpq_pkg.sv
rtl/core/mhpq_ram.sv
rtl/core/mhpq_ctrl.sv
rtl/core/max_heap_priority_queue.sv
tb/heap_result_checker.sv
tb/max_heap_priority_queue_tb.sv
